// ----- rtl/core/pdu_pkg.sv -----
// Package: shared types and constants of the packed dump unpacker.
`timescale 1ns / 1ps

package pdu_pkg;

    localparam int unsigned VALUES_PER_PACKET = 7;
    localparam int unsigned POS_W             = 3;
    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SKIP_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_LAST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_TOTAL = 2'd2;

    localparam logic [BYTE_W-1:0] SKIP_FIRST_RST  = 8'd109;
    localparam logic [BYTE_W-1:0] SKIP_LAST_RST   = 8'd119;
    localparam logic [BYTE_W-1:0] PARAM_TOTAL_RST = 8'd200;

    localparam logic [POS_W-1:0] POS_HEADER = '0;
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(VALUES_PER_PACKET);

    typedef struct packed {
        logic [BYTE_W-1:0] skip_first;
        logic [BYTE_W-1:0] skip_last;
        logic [BYTE_W-1:0] param_total;
    } cfg_t;

    typedef struct packed {
        logic              fire;
        logic [BYTE_W-1:0] index;
        logic [BYTE_W-1:0] value;
        logic              last;
    } res_t;

endpackage

// ----- rtl/core/packed_dump_unpacker.sv -----
// Top level: configuration registers, request handshake and result register.
// A result is registered and appears in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; the single result register sets this rate
// and stalls input only while it holds a result that is not taken.
// Reset: rst_n clears the dump state and the result valid, and loads the
// skip range and slot total with 109, 119 and 200.
`timescale 1ns / 1ps

module packed_dump_unpacker
    import pdu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    dump_byte,
    input  logic                 start_req,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    param_index,
    output logic [BYTE_W-1:0]    param_value,
    output logic                 last
);

    cfg_t              cfg_reg;
    res_t              res;
    logic              take;
    logic              out_load;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] index_reg;
    logic [BYTE_W-1:0] value_reg;
    logic              last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_first  <= SKIP_FIRST_RST;
            cfg_reg.skip_last   <= SKIP_LAST_RST;
            cfg_reg.param_total <= PARAM_TOTAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SKIP_FIRST:  cfg_reg.skip_first  <= cfg_data;
                REG_SKIP_LAST:   cfg_reg.skip_last   <= cfg_data;
                REG_PARAM_TOTAL: cfg_reg.param_total <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign in_stall = out_valid_reg & out_stall;
    assign take     = in_valid & ~in_stall;
    assign out_load = ~out_valid_reg | ~out_stall;

    pdu_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .dump_byte (dump_byte),
        .start_req (start_req),
        .cfg       (cfg_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= res.fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && res.fire)
        begin
            index_reg <= res.index;
            value_reg <= res.value;
            last_reg  <= res.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign param_index = index_reg;
    assign param_value = value_reg;
    assign last        = last_reg;

endmodule

// ----- rtl/core/pdu_core.sv -----
// Dump state tracking and value reassembly for one byte per cycle while take is high.
`timescale 1ns / 1ps

module pdu_core
    import pdu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [BYTE_W-1:0] dump_byte,
    input  logic              start_req,
    input  cfg_t              cfg,
    output res_t              res
);

    logic [BYTE_W-1:0] top_bits_reg, top_bits_next;
    logic [POS_W-1:0]  packet_pos_reg, packet_pos_next;
    logic [BYTE_W-1:0] slot_count_reg, slot_count_next;
    logic              active_reg, active_next;

    logic              eff_active;
    logic [POS_W-1:0]  eff_pos;
    logic [BYTE_W-1:0] eff_slot;
    logic [POS_W-1:0]  bitpos;
    logic [BYTE_W-1:0] final_idx;
    logic              skipped;
    logic              is_final;

    assign eff_active = start_req | active_reg;
    assign eff_pos    = start_req ? POS_HEADER : packet_pos_reg;
    assign eff_slot   = start_req ? '0 : slot_count_reg;
    assign bitpos     = eff_pos - POS_W'(1);
    assign final_idx  = cfg.param_total - BYTE_W'(1);
    assign is_final   = (eff_slot == final_idx);
    assign skipped    = (cfg.skip_first <= cfg.skip_last)
                     && (eff_slot >= cfg.skip_first)
                     && (eff_slot <= cfg.skip_last);

    always_comb
    begin
        top_bits_next   = top_bits_reg;
        packet_pos_next = packet_pos_reg;
        slot_count_next = slot_count_reg;
        active_next     = active_reg;
        res.fire        = 1'b0;
        res.index       = eff_slot;
        res.value       = {top_bits_reg[bitpos], dump_byte[BYTE_W-2:0]};
        res.last        = is_final;
        if (take && eff_active)
        begin
            active_next = 1'b1;
            if (eff_pos == POS_HEADER)
            begin
                top_bits_next   = dump_byte;
                packet_pos_next = POS_W'(1);
                slot_count_next = eff_slot;
            end
            else
            begin
                res.fire        = ~skipped;
                slot_count_next = eff_slot + BYTE_W'(1);
                packet_pos_next = (eff_pos == POS_LAST) ? POS_HEADER : eff_pos + POS_W'(1);
                if (is_final)
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_bits_reg   <= '0;
            packet_pos_reg <= POS_HEADER;
            slot_count_reg <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            top_bits_reg   <= top_bits_next;
            packet_pos_reg <= packet_pos_next;
            slot_count_reg <= slot_count_next;
            active_reg     <= active_next;
        end
    end

`ifndef SYNTH
    a_idle_byte_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        take && !start_req && !active_reg |=>
            !active_reg && $stable(slot_count_reg) && $stable(packet_pos_reg))
        else $error("byte outside a dump changed the dump state");

    a_start_is_header: assert property (@(posedge clk) disable iff (!rst_n)
        take && start_req |=>
            active_reg && packet_pos_reg == POS_W'(1) && slot_count_reg == '0)
        else $error("start byte was not taken as the first header");

    a_pos_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        packet_pos_reg <= POS_LAST)
        else $error("packet position ran past the packet");

    a_no_result_on_header: assert property (@(posedge clk) disable iff (!rst_n)
        res.fire |=> slot_count_reg == $past(eff_slot) + BYTE_W'(1))
        else $error("result given without advancing the slot count");
`endif

endmodule
